// ----- rtl/cmtm_pkg.sv -----
// Shared codes, widths and types for the checked monotonic time monitor.
`default_nettype none

package cmtm_pkg;

    // Counter and result widths
    localparam int CNT_W       = 32;
    localparam int OUT_TIME_W  = 32;
    localparam int STATUS_W    = 2;
    localparam int VERDICT_W   = 3;
    localparam int CAUSE_W     = 2;
    localparam int OUT_USER_W  = VERDICT_W;
    localparam int OUT_FIELD_W = OUT_TIME_W + 1 + CAUSE_W + 6 * CNT_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    // Raw source status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FAILED    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 2'd3;

    // Verdict codes
    localparam logic [VERDICT_W-1:0] V_NONE          = 3'd0;
    localparam logic [VERDICT_W-1:0] V_NOT_READY     = 3'd1;
    localparam logic [VERDICT_W-1:0] V_SOURCE_FAILED = 3'd2;
    localparam logic [VERDICT_W-1:0] V_ROLLBACK      = 3'd3;
    localparam logic [VERDICT_W-1:0] V_FAULT_LATCHED = 3'd4;

    // Latched fault causes (verdict coding, two bits)
    localparam logic [CAUSE_W-1:0] C_NONE          = 2'd0;
    localparam logic [CAUSE_W-1:0] C_SOURCE_FAILED = 2'd2;
    localparam logic [CAUSE_W-1:0] C_ROLLBACK      = 2'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Statistics counters
    typedef struct packed {
        logic [CNT_W-1:0] successes;
        logic [CNT_W-1:0] rollbacks;
        logic [CNT_W-1:0] failures;
        logic [CNT_W-1:0] unready_reads;
        logic [CNT_W-1:0] refusals;
        logic [CNT_W-1:0] attempts;
    } t_counters;

    // Saturating increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == CNT_MAX) ? c : c + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/checked_monotonic_time_monitor.sv -----
// Top level of the checked monotonic time monitor: sample checks, fault latch, counters.
// Each sample passes through the input register and then the result register before
//   its output transfer.
// Throughput: one sample per cycle; the input register and result register form a
//   two-stage pipeline that advances whenever the result register is free or drained.
// The verdict logic reads the state registers, which update as each sample leaves
//   the input register, so consecutive samples see each other's effect.
// Reset (synchronous, active low) clears both stages, counters, fault latch and last time.
`default_nettype none

module checked_monotonic_time_monitor #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // Slave side
    input  wire logic                                   i_s_tvalid,
    output logic                                        o_s_tready,
    // tdata: sample_ms [TIME_WIDTH-1:0], zero padding to whole bytes
    input  wire logic [((TIME_WIDTH + 7) / 8) * 8-1:0]  i_s_tdata,
    // tuser: sample_status [1:0]
    input  wire logic [cmtm_pkg::STATUS_W-1:0]          i_s_tuser,
    // Master side
    output logic                                        o_m_tvalid,
    input  wire logic                                   i_m_tready,
    // tdata: time_ms [31:0], fault_flag [32], fault_cause [34:33],
    //   attempt_count [66:35], refusal_count [98:67], not_ready_count [130:99],
    //   failure_count [162:131], rollback_count [194:163], success_count [226:195],
    //   zero padding [231:227]
    output logic [cmtm_pkg::OUT_DATA_W-1:0]             o_m_tdata,
    // tuser: verdict [2:0]
    output logic [cmtm_pkg::OUT_USER_W-1:0]             o_m_tuser
);
    import cmtm_pkg::*;

    // Input register
    logic                  r_in_valid;
    logic [STATUS_W-1:0]   r_in_status;
    logic [TIME_WIDTH-1:0] r_in_ms;

    // Monitor state
    t_counters             r_cnt,     n_cnt;
    logic                  r_latched, n_latched;
    logic [CAUSE_W-1:0]    r_cause,   n_cause;
    logic                  r_seen,    n_seen;
    logic [TIME_WIDTH-1:0] r_last_ms, n_last_ms;

    // Result register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic [VERDICT_W-1:0]  r_out_verdict, n_verdict;

    logic                  advance;
    logic [OUT_TIME_W-1:0] time_out;

    // Move a sample on when the result register is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || !r_out_valid || i_m_tready;

    // Capture the input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_status <= i_s_tuser;
            r_in_ms     <= i_s_tdata[TIME_WIDTH-1:0];
        end
    end

    // Judge the registered sample against the current state
    always_comb begin
        n_cnt     = r_cnt;
        n_latched = r_latched;
        n_cause   = r_cause;
        n_seen    = r_seen;
        n_last_ms = r_last_ms;
        n_verdict = V_NONE;
        time_out  = '0;

        n_cnt.attempts = sat_inc(r_cnt.attempts);
        if (r_latched) begin
            n_cnt.refusals = sat_inc(r_cnt.refusals);
            n_verdict      = V_FAULT_LATCHED;
        end else if (r_in_status == ST_NOT_READY) begin
            n_cnt.unready_reads = sat_inc(r_cnt.unready_reads);
            n_verdict           = V_NOT_READY;
        end else if (r_in_status == ST_FAILED || r_in_status == ST_UNKNOWN) begin
            n_latched      = 1'b1;
            n_cause        = C_SOURCE_FAILED;
            n_cnt.failures = sat_inc(r_cnt.failures);
            n_verdict      = V_SOURCE_FAILED;
        end else if (r_seen && (r_in_ms < r_last_ms)) begin
            n_latched       = 1'b1;
            n_cause         = C_ROLLBACK;
            n_cnt.rollbacks = sat_inc(r_cnt.rollbacks);
            n_verdict       = V_ROLLBACK;
        end else begin
            n_seen          = 1'b1;
            n_last_ms       = r_in_ms;
            n_cnt.successes = sat_inc(r_cnt.successes);
            n_verdict       = V_NONE;
            time_out        = OUT_TIME_W'(r_in_ms);
        end
    end

    assign n_out_data = OUT_DATA_W'({n_cnt, (n_latched ? n_cause : C_NONE), n_latched,
                                     time_out});

    // Update the state as the sample leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_latched <= 1'b0;
            r_cause   <= C_NONE;
            r_seen    <= 1'b0;
            r_last_ms <= '0;
        end else if (advance) begin
            r_cnt     <= n_cnt;
            r_latched <= n_latched;
            r_cause   <= n_cause;
            r_seen    <= n_seen;
            r_last_ms <= n_last_ms;
        end
    end

    // Hold the result until the master side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data    <= n_out_data;
            r_out_verdict <= n_verdict;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_verdict;

    // The fault latch stays set until reset
    a_latch_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_latched |=> r_latched)
        else $error("fault latch cleared without reset");

    // A latched fault always carries a real cause, and no cause without a fault
    a_cause_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_latched ? (r_cause == C_SOURCE_FAILED || r_cause == C_ROLLBACK)
                  : (r_cause == C_NONE))
        else $error("fault cause inconsistent with latch");

    // An accepted time never comes with the fault flag set
    a_none_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_verdict == V_NONE) |-> !r_out_data[OUT_TIME_W])
        else $error("accepted sample reported with fault flag");

    // A refusal is only reported with the fault flag set
    a_refusal_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_verdict == V_FAULT_LATCHED) |-> r_out_data[OUT_TIME_W])
        else $error("refusal reported without fault flag");

endmodule

`default_nettype wire
